>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define SRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/srt_pkg.sv
`default_nettype none

package srt_pkg;

    localparam int CAPACITY = 64;
    localparam int TOTAL_W  = 7;

    // command codes
    localparam logic [2:0] KIND_INSERT     = 3'd0;
    localparam logic [2:0] KIND_SEARCH     = 3'd1;
    localparam logic [2:0] KIND_REMOVE_MIN = 3'd2;
    localparam logic [2:0] KIND_REMOVE_MAX = 3'd3;
    localparam logic [2:0] KIND_REMOVE_KEY = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] rec_key;
        logic [7:0]         rec_sex;
        logic [31:0]        rec_weight;
        logic [31:0]        rec_height;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [7:0]         out_sex;
        logic [31:0]        out_weight;
        logic [31:0]        out_height;
        logic [TOTAL_W-1:0] entry_total;
    } result_t;

    // one stored record
    typedef struct packed {
        logic signed [31:0] key;
        logic [7:0]         sex;
        logic [31:0]        weight;
        logic [31:0]        height;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

`default_nettype wire

>>> rtl/core/sorted_record_table_top.sv
// channel  | handshake           | word                 | notes
// ---------+---------------------+----------------------+------------------------------
// command  | start / busy        | cmd    (cmd_t)       | taken when start & !busy
// result   | done (one cycle)    | result (result_t)    | one word per command, no stall
//
// Records sit in one single-port-write RAM in ascending key order; each state does at most
// one RAM read or write; read data is registered, valid in the cycle after the read.
// Per command: each entry passed in the search costs a read and a compare, each record
// moved a read and a write, then the last compare, final write and result follow.
// Reset clears the count and control only; RAM contents need no clearing pass.
// busy drops in the cycle done is shown; the receiver cannot stall the result.
`default_nettype none

module sorted_record_table_top #(
    parameter int CAPACITY = srt_pkg::CAPACITY
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire srt_pkg::cmd_t   cmd,
    output logic                 busy,
    output logic                 done,
    output srt_pkg::result_t     result
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_TAKE_RD,
        ST_TAKE_CAP,
        ST_DN_RD,
        ST_DN_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_FIN
    } state_t;

    state_t              state_reg, state_next;
    srt_pkg::cmd_t       cmd_reg, cmd_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    srt_pkg::rec_t       out_rec_reg, out_rec_next;
    logic [1:0]          status_reg, status_next;
    logic                done_reg, done_next;
    srt_pkg::result_t    result_reg, result_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [srt_pkg::REC_W-1:0] ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [srt_pkg::REC_W-1:0] ram_rdata;

    srt_pkg::rec_t       rd_rec;
    srt_pkg::rec_t       new_rec;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    idx_dec;
    logic [CNT_W-1:0]    count_dec;
    logic                table_full;

    srt_ram #(
        .WIDTH(srt_pkg::REC_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_rec     = srt_pkg::rec_t'(ram_rdata);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign count_dec  = count_reg - CNT_W'(1);
    assign table_full = (count_reg >= CNT_W'(CAPACITY));

    always_comb
    begin
        new_rec.key    = cmd_reg.rec_key;
        new_rec.sex    = cmd_reg.rec_sex;
        new_rec.weight = cmd_reg.rec_weight;
        new_rec.height = cmd_reg.rec_height;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        out_rec_next = out_rec_reg;
        status_next  = status_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[ADDR_W-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd;
                    idx_next     = '0;
                    out_rec_next = '0;
                    status_next  = srt_pkg::STATUS_OK;
                    unique case (cmd.kind) inside
                        srt_pkg::KIND_INSERT, srt_pkg::KIND_SEARCH,
                        srt_pkg::KIND_REMOVE_KEY:
                        begin
                            state_next = ST_SCAN;
                        end
                        srt_pkg::KIND_REMOVE_MIN:
                        begin
                            pos_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = srt_pkg::STATUS_NOT_FOUND;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_TAKE_RD;
                            end
                        end
                        srt_pkg::KIND_REMOVE_MAX:
                        begin
                            pos_next = count_dec;
                            if (count_reg == '0)
                            begin
                                status_next = srt_pkg::STATUS_NOT_FOUND;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_TAKE_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
                else if (cmd_reg.kind == srt_pkg::KIND_INSERT)
                begin
                    // key goes past the last record
                    if (table_full)
                    begin
                        status_next = srt_pkg::STATUS_FULL;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        state_next = ST_UP_RD;
                    end
                end
                else
                begin
                    status_next = srt_pkg::STATUS_NOT_FOUND;
                    state_next  = ST_FIN;
                end
            end

            ST_SCAN_CMP:
            begin
                if (rd_rec.key < cmd_reg.rec_key)
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SCAN;
                end
                else if (rd_rec.key == cmd_reg.rec_key)
                begin
                    if (cmd_reg.kind == srt_pkg::KIND_INSERT)
                    begin
                        status_next = srt_pkg::STATUS_DUPLICATE;
                        state_next  = ST_FIN;
                    end
                    else if (cmd_reg.kind == srt_pkg::KIND_SEARCH)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        out_rec_next = rd_rec;
                        state_next   = ST_DN_RD;
                    end
                end
                else if (cmd_reg.kind == srt_pkg::KIND_INSERT)
                begin
                    if (table_full)
                    begin
                        status_next = srt_pkg::STATUS_FULL;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        state_next = ST_UP_RD;
                    end
                end
                else
                begin
                    status_next = srt_pkg::STATUS_NOT_FOUND;
                    state_next  = ST_FIN;
                end
            end

            ST_TAKE_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = pos_reg[ADDR_W-1:0];
                state_next = ST_TAKE_CAP;
            end

            ST_TAKE_CAP:
            begin
                out_rec_next = rd_rec;
                idx_next     = pos_reg;
                state_next   = ST_DN_RD;
            end

            // close the gap: mem[i] = mem[i+1] up to the last record
            ST_DN_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_inc[ADDR_W-1:0];
                    state_next = ST_DN_WR;
                end
                else
                begin
                    count_next = count_dec;
                    state_next = ST_FIN;
                end
            end

            ST_DN_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = ST_DN_RD;
            end

            // open a slot: mem[i] = mem[i-1] down to the insert position
            ST_UP_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_dec[ADDR_W-1:0];
                    state_next = ST_UP_WR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[ADDR_W-1:0];
                    ram_wdata  = new_rec;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_FIN;
                end
            end

            ST_UP_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_dec;
                state_next = ST_UP_RD;
            end

            ST_FIN:
            begin
                result_next.status      = status_reg;
                result_next.out_key     = out_rec_reg.key;
                result_next.out_sex     = out_rec_reg.sex;
                result_next.out_weight  = out_rec_reg.weight;
                result_next.out_height  = out_rec_reg.height;
                result_next.entry_total = srt_pkg::TOTAL_W'(count_reg);
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        out_rec_reg <= out_rec_next;
        status_reg  <= status_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/srt_ram.sv
`default_nettype none

module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/srt_checker.sv
`default_nettype none
`include "assert_macros.svh"

module srt_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire srt_pkg::result_t result
);

    logic failed;
    logic no_rec;

    assign failed = done && (result.status != srt_pkg::STATUS_OK);
    assign no_rec = (result.out_key == 0) && (result.out_sex == 0) &&
                    (result.out_weight == 0) && (result.out_height == 0);

    `SRT_ASSERT(a_done_when_free, clk, rst_n, done |-> !busy, "result shown while busy")
    `SRT_ASSERT(a_take_goes_busy, clk, rst_n, (start && !busy) |=> busy, "command taken, no busy")
    `SRT_ASSERT(a_done_single, clk, rst_n, done |=> !done, "two result words for one command")
    `SRT_ASSERT(a_fail_zero, clk, rst_n, failed |-> no_rec, "failed command returned a record")

endmodule

bind sorted_record_table_top srt_checker u_srt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

`default_nettype wire
